// ===== sv/msec_pkg.sv =====
// Package for the lowest-score eviction cache: field widths, action codes,
// the stored entry layout and the compare result bundle.
// No dependencies.
package msec_pkg;

    localparam int KEY_W   = 32;
    localparam int SCORE_W = 16;
    localparam int KIND_W  = 3;
    localparam int ACT_W   = 2;
    localparam int TOT_W   = 64;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // One stored slot
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [KIND_W-1:0]  kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Status from the shared compare unit
    typedef struct packed {
        logic match;
        logic lower;
    } cmp_res_t;

endpackage

// ===== sv/msec_req_if.sv =====
// Request channel of the lowest-score eviction cache: valid/ready plus
// action, key, score and kind tag. Depends on msec_pkg.
interface msec_req_if;
    import msec_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [KEY_W-1:0]     key;
    logic [SCORE_W-1:0]   score;
    logic [KIND_W-1:0]    kind_tag;

    modport source (output valid, action, key, score, kind_tag, input ready);
    modport sink   (input valid, action, key, score, kind_tag, output ready);
endinterface

// ===== sv/msec_rsp_if.sv =====
// Response channel of the lowest-score eviction cache: valid/ready plus
// hit, score, eviction flag and the three running totals. Depends on msec_pkg.
interface msec_rsp_if;
    import msec_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [SCORE_W-1:0] found_score;
    logic               evicted;
    logic [TOT_W-1:0]   hit_total;
    logic [TOT_W-1:0]   miss_total;
    logic [TOT_W-1:0]   evict_total;

    modport source (output valid, hit, found_score, evicted, hit_total, miss_total,
                    evict_total, input ready);
    modport sink   (input valid, hit, found_score, evicted, hit_total, miss_total,
                    evict_total, output ready);
endinterface

// ===== sv/min_score_eviction_cache.sv =====
// Top level of the lowest-score eviction cache: sequencer, valid bits,
// counters and response register. Depends on msec_pkg, msec_req_if,
// msec_rsp_if, msec_ram and msec_cmp.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------------
//  req     | in  | action, key, score, kind_tag
//  rsp     | out | hit, found_score, evicted, hit_total, miss_total, evict_total
//
// One request at a time; slot RAM is read one slot per cycle through one compare unit.
// Lookup stops at the first match. Insert with a free slot, clear and an unused code
// skip the scan; insert into a full store scans every slot, then writes the lowest.
// Reset and clear drop all valid bits at once; no clearing pass is needed.
// A stalled response holds in its register; the next request is taken meanwhile.
module min_score_eviction_cache #(
    parameter int SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    msec_req_if.sink    req,
    msec_rsp_if.source  rsp
);
    import msec_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] END_CNT = CNT_W'(SLOTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_MIN   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [TOT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [TOT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic [TOT_W-1:0]   evict_cnt_reg, evict_cnt_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [ACT_W-1:0]   act_reg, act_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [SCORE_W-1:0] min_score_reg, min_score_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic               res_hit_reg, res_hit_next;
    logic [SCORE_W-1:0] res_found_reg, res_found_next;
    logic               res_evict_reg, res_evict_next;

    logic               rsp_hit_reg;
    logic [SCORE_W-1:0] rsp_found_reg;
    logic               rsp_evict_reg;
    logic [TOT_W-1:0]   rsp_hit_tot_reg;
    logic [TOT_W-1:0]   rsp_miss_tot_reg;
    logic [TOT_W-1:0]   rsp_evict_tot_reg;

    logic               issue;
    logic               load;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic [IDX_W-1:0]   free_idx;
    logic               any_free;
    cmp_res_t           cmp;

    msec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    msec_cmp u_cmp (
        .entry       (ram_rdata),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .key         (key_reg),
        .min_score   (min_score_reg),
        .first       (cmp_idx_reg == '0),
        .res         (cmp)
    );

    // Find the lowest-indexed empty slot
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        act_next       = act_reg;
        key_next       = key_reg;
        score_next     = score_reg;
        kind_next      = kind_reg;
        min_score_next = min_score_reg;
        min_idx_next   = min_idx_reg;
        res_hit_next   = res_hit_reg;
        res_found_next = res_found_reg;
        res_evict_next = res_evict_reg;
        issue          = 1'b0;
        load           = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = min_idx_reg;
        ram_wdata      = '{key: key_reg, score: score_reg, kind: kind_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next       = req.action;
                    key_next       = req.key;
                    score_next     = req.score;
                    kind_next      = req.kind_tag;
                    res_hit_next   = 1'b0;
                    res_found_next = '0;
                    res_evict_next = 1'b0;
                    rd_idx_next    = '0;
                    pend_next      = 1'b0;
                    state_next     = ST_DONE;
                    case (req.action)
                        ACT_LOOKUP:
                        begin
                            state_next = ST_LOOK;
                        end
                        ACT_INSERT:
                        begin
                            if (any_free)
                            begin
                                // Fill the empty slot straight from the request
                                ram_we               = 1'b1;
                                ram_waddr            = free_idx;
                                ram_wdata            = '{key: req.key, score: req.score,
                                                         kind: req.kind_tag};
                                valid_next[free_idx] = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_MIN;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LOOK, ST_MIN:
            begin
                // Stream slot reads; compare each slot in the cycle after its read
                issue        = (rd_idx_reg != END_CNT);
                pend_next    = issue;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (state_reg == ST_LOOK)
                    begin
                        if (cmp.match)
                        begin
                            res_hit_next   = 1'b1;
                            res_found_next = ram_rdata.score;
                            state_next     = ST_DONE;
                        end
                        else if (!issue)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (cmp.lower)
                        begin
                            min_score_next = ram_rdata.score;
                            min_idx_next   = cmp_idx_reg;
                        end
                        if (!issue)
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                // Replace the lowest-score slot
                ram_we         = 1'b1;
                ram_waddr      = min_idx_reg;
                res_evict_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load           = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (act_reg)
                        ACT_LOOKUP:
                        begin
                            if (res_hit_reg)
                            begin
                                hit_cnt_next = hit_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                miss_cnt_next = miss_cnt_reg + 1'b1;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (res_evict_reg)
                            begin
                                evict_cnt_next = evict_cnt_reg + 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            hit_cnt_next   = '0;
                            miss_cnt_next  = '0;
                            evict_cnt_next = '0;
                        end
                        default:
                        begin
                            hit_cnt_next = hit_cnt_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            cmp_idx_reg   <= cmp_idx_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        score_reg     <= score_next;
        kind_reg      <= kind_next;
        min_score_reg <= min_score_next;
        min_idx_reg   <= min_idx_next;
        res_hit_reg   <= res_hit_next;
        res_found_reg <= res_found_next;
        res_evict_reg <= res_evict_next;
        if (load)
        begin
            rsp_hit_reg       <= res_hit_reg;
            rsp_found_reg     <= res_found_reg;
            rsp_evict_reg     <= res_evict_reg;
            rsp_hit_tot_reg   <= hit_cnt_next;
            rsp_miss_tot_reg  <= miss_cnt_next;
            rsp_evict_tot_reg <= evict_cnt_next;
        end
    end

    // Drive the channels
    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.found_score = rsp_found_reg;
    assign rsp.evicted     = rsp_evict_reg;
    assign rsp.hit_total   = rsp_hit_tot_reg;
    assign rsp.miss_total  = rsp_miss_tot_reg;
    assign rsp.evict_total = rsp_evict_tot_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (&valid_reg))
        else $error("eviction with an empty slot available");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response loaded outside the finish step");

    a_hit_or_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_hit_reg && rsp_evict_reg))
        else $error("response flags both hit and eviction");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOOK) || (state_reg == ST_MIN)) |-> (rd_idx_reg <= END_CNT))
        else $error("scan index ran past the last slot");
`endif
endmodule

// ===== sv/msec_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module msec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/msec_cmp.sv =====
// Shared compare unit of the cache scan: key match against a valid slot and
// score less-than against the running minimum. Depends on msec_pkg.
module msec_cmp (
    input  msec_pkg::entry_t              entry,
    input  logic                          entry_valid,
    input  logic [msec_pkg::KEY_W-1:0]    key,
    input  logic [msec_pkg::SCORE_W-1:0]  min_score,
    input  logic                          first,
    output msec_pkg::cmp_res_t            res
);
    import msec_pkg::*;

    // Match on a valid slot; the first slot always seeds the minimum
    always_comb
    begin
        res.match = entry_valid && (entry.key == key);
        res.lower = first || (entry.score < min_score);
    end
endmodule
